### rtl/core/ptts_pkg.sv
// Shared types and constants for the periodic task table scheduler core.
// Holds command codes, the control-word layout and the control store.
// No dependencies.
`default_nettype none

package ptts_pkg;

  // Command codes carried by in_cmd
  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_REGISTER = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;

  // Result field widths
  localparam int unsigned OUT_SLOT_W = 4;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned TIME_W     = 32;

  // At most this many results are reported for one tick
  localparam int unsigned MAX_REPORTS = 16;
  localparam int unsigned REP_W       = $clog2(MAX_REPORTS + 1);

  // Step counter addresses of the control program
  localparam int unsigned PC_W = 3;
  localparam logic [PC_W-1:0] PC_IDLE     = 3'd0;
  localparam logic [PC_W-1:0] PC_CLEAR    = 3'd1;
  localparam logic [PC_W-1:0] PC_REG      = 3'd2;
  localparam logic [PC_W-1:0] PC_TICK_RD  = 3'd3;
  localparam logic [PC_W-1:0] PC_TICK_EV  = 3'd4;
  localparam logic [PC_W-1:0] PC_TICK_END = 3'd5;

  // How the next step is chosen
  typedef enum logic [1:0] {
    BR_DISPATCH  = 2'd0,  // wait for a command, jump on its code
    BR_GOTO      = 2'd1,  // jump to target unconditionally
    BR_SCAN_DONE = 2'd2,  // repeat until a free slot or the last slot
    BR_WALK_DONE = 2'd3   // repeat until the last slot has been checked
  } br_t;

  typedef struct packed {
    logic            clr_valid;  // drop every valid mark
    logic            reg_scan;   // test one slot for a free entry
    logic            rd_first;   // prime the slot memory read at slot 0
    logic            tick_eval;  // check one slot against now
    logic            flush;      // release the held result as the last one
    br_t             br;
    logic [PC_W-1:0] target;
  } uword_t;

  // Control store: one control word per step
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    w        = '0;
    w.br     = BR_GOTO;
    w.target = PC_IDLE;
    case (pc)
      PC_IDLE: begin
        w.br = BR_DISPATCH;
      end
      PC_CLEAR: begin
        w.clr_valid = 1'b1;
      end
      PC_REG: begin
        w.reg_scan = 1'b1;
        w.br       = BR_SCAN_DONE;
      end
      PC_TICK_RD: begin
        w.rd_first = 1'b1;
        w.target   = PC_TICK_EV;
      end
      PC_TICK_EV: begin
        w.tick_eval = 1'b1;
        w.br        = BR_WALK_DONE;
        w.target    = PC_TICK_END;
      end
      PC_TICK_END: begin
        w.flush = 1'b1;
      end
      default: begin
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/core/periodic_task_table_scheduler_core.sv
// Top level of the periodic task table scheduler: control sequencer, slot
// memories and result register. Depends on ptts_pkg.
`default_nettype none

// A command transaction is taken when start is high and busy is low. A clear
// returns nothing. A register scans the valid marks from slot 0, one slot per
// cycle, and returns exactly one result. A tick walks every slot through the
// registered read port of the slot memory, one slot per cycle behind a read
// prime step, whatever is due. Each result appears on the out_ ports for
// exactly one cycle with out_strobe high; the receiver cannot stall the block,
// so results must be taken as they come. A tick reports at most sixteen due
// slots, with out_last on the final one; further due slots are still
// rescheduled. The slot tag, due time and period stores are not cleared at
// reset; only the valid marks are, and a slot's stored values are used only
// once it has been written.
module periodic_task_table_scheduler_core #(
  parameter int unsigned SLOTS = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  output logic                                 busy,
  input  wire  [1:0]                           in_cmd,
  input  wire  [ptts_pkg::TIME_W-1:0]          in_now_ms,
  input  wire  [ptts_pkg::TIME_W-1:0]          in_first_due_ms,
  input  wire  [ptts_pkg::TIME_W-1:0]          in_period_ms,
  input  wire  [ptts_pkg::TAG_W-1:0]           in_task_tag,
  output logic                                 out_strobe,
  output logic [ptts_pkg::OUT_SLOT_W-1:0]      out_slot,
  output logic [ptts_pkg::TAG_W-1:0]           out_fired_tag,
  output logic                                 out_stored,
  output logic                                 out_fired,
  output logic                                 out_last
);

  import ptts_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // Sequencer state
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  uword_t            uw;
  logic              accept;
  logic              idx_last;

  // Command operands, held for the whole transaction
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] first_due_r;
  logic [TIME_W-1:0] period_r;
  logic [TAG_W-1:0]  tag_r;

  // Slot table
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [TAG_W-1:0]  tag_mem    [SLOTS];
  logic [TIME_W-1:0] due_mem    [SLOTS];
  logic [TIME_W-1:0] period_mem [SLOTS];
  logic [IDX_W-1:0]  rd_addr;
  logic [TAG_W-1:0]  rd_tag_r;
  logic [TIME_W-1:0] rd_due_r;
  logic [TIME_W-1:0] rd_period_r;
  logic              mem_we_all;
  logic              mem_we_due;
  logic [TIME_W-1:0] mem_wr_due;

  // Tick result holding: a due slot waits here until the walk shows
  // whether another one follows, which settles its last flag
  logic              pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]  pend_slot_r, pend_slot_nxt;
  logic [TAG_W-1:0]  pend_tag_r, pend_tag_nxt;
  logic [REP_W-1:0]  rep_cnt_r, rep_cnt_nxt;

  // Result register
  logic                  out_strobe_r, out_strobe_nxt;
  logic [IDX_W-1:0]      out_idx_r, out_idx_nxt;
  logic [TAG_W-1:0]      out_tag_r, out_tag_nxt;
  logic                  out_stored_r, out_stored_nxt;
  logic                  out_fired_r, out_fired_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [IDX_W+3:0]      out_idx_wide;

  logic              slot_free;
  logic              slot_due_now;
  logic [TIME_W-1:0] next_due;

  assign busy     = (pc_r != PC_IDLE);
  assign accept   = start && !busy;
  assign uw       = ucode_rom(pc_r);
  assign idx_last = (idx_r == LAST_IDX);

  assign slot_free    = !valid_r[idx_r];
  assign slot_due_now = valid_r[idx_r] && (rd_due_r <= now_r);
  assign next_due     = now_r + rd_period_r;

  // Read the next slot while the current one is checked
  assign rd_addr = (uw.rd_first || idx_last) ? '0 : idx_r + IDX_W'(1);

  // Step counter and slot index
  always_comb begin
    pc_nxt  = pc_r;
    idx_nxt = idx_r;
    case (uw.br)
      BR_DISPATCH: begin
        if (accept) begin
          idx_nxt = '0;
          case (in_cmd)
            CMD_CLEAR:    pc_nxt = PC_CLEAR;
            CMD_REGISTER: pc_nxt = PC_REG;
            CMD_TICK:     pc_nxt = PC_TICK_RD;
            default:      pc_nxt = PC_IDLE;
          endcase
        end
      end
      BR_GOTO: begin
        pc_nxt = uw.target;
      end
      BR_SCAN_DONE: begin
        if (slot_free || idx_last) begin
          pc_nxt = uw.target;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      BR_WALK_DONE: begin
        if (idx_last) begin
          pc_nxt = uw.target;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        pc_nxt = PC_IDLE;
      end
    endcase
    if (uw.rd_first) begin
      idx_nxt = '0;
    end
  end

  // Datapath actions selected by the control word
  always_comb begin
    valid_nxt      = valid_r;
    mem_we_all     = 1'b0;
    mem_we_due     = 1'b0;
    mem_wr_due     = first_due_r;
    pend_v_nxt     = pend_v_r;
    pend_slot_nxt  = pend_slot_r;
    pend_tag_nxt   = pend_tag_r;
    rep_cnt_nxt    = rep_cnt_r;
    out_strobe_nxt = 1'b0;
    out_idx_nxt    = out_idx_r;
    out_tag_nxt    = out_tag_r;
    out_stored_nxt = out_stored_r;
    out_fired_nxt  = out_fired_r;
    out_last_nxt   = out_last_r;

    if (accept) begin
      pend_v_nxt  = 1'b0;
      rep_cnt_nxt = '0;
    end

    if (uw.clr_valid) begin
      valid_nxt = '0;
    end

    // Register: take the first free slot, or report a full table
    if (uw.reg_scan) begin
      if (slot_free) begin
        valid_nxt[idx_r] = 1'b1;
        mem_we_all       = 1'b1;
        out_strobe_nxt   = 1'b1;
        out_idx_nxt      = idx_r;
        out_tag_nxt      = '0;
        out_stored_nxt   = 1'b1;
        out_fired_nxt    = 1'b0;
        out_last_nxt     = 1'b1;
      end else if (idx_last) begin
        out_strobe_nxt = 1'b1;
        out_idx_nxt    = '0;
        out_tag_nxt    = '0;
        out_stored_nxt = 1'b0;
        out_fired_nxt  = 1'b0;
        out_last_nxt   = 1'b1;
      end
    end

    // Tick: reschedule a due slot; below the report limit, release the held one and hold this one
    if (uw.tick_eval && slot_due_now) begin
      mem_we_due = 1'b1;
      mem_wr_due = next_due;
      if (rep_cnt_r < REP_W'(MAX_REPORTS)) begin
        if (pend_v_r) begin
          out_strobe_nxt = 1'b1;
          out_idx_nxt    = pend_slot_r;
          out_tag_nxt    = pend_tag_r;
          out_stored_nxt = 1'b0;
          out_fired_nxt  = 1'b1;
          out_last_nxt   = 1'b0;
        end
        pend_v_nxt    = 1'b1;
        pend_slot_nxt = idx_r;
        pend_tag_nxt  = rd_tag_r;
        rep_cnt_nxt   = rep_cnt_r + REP_W'(1);
      end
    end

    if (uw.flush && pend_v_r) begin
      out_strobe_nxt = 1'b1;
      out_idx_nxt    = pend_slot_r;
      out_tag_nxt    = pend_tag_r;
      out_stored_nxt = 1'b0;
      out_fired_nxt  = 1'b1;
      out_last_nxt   = 1'b1;
      pend_v_nxt     = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= PC_IDLE;
      idx_r        <= '0;
      valid_r      <= '0;
      pend_v_r     <= 1'b0;
      rep_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      pc_r         <= pc_nxt;
      idx_r        <= idx_nxt;
      valid_r      <= valid_nxt;
      pend_v_r     <= pend_v_nxt;
      rep_cnt_r    <= rep_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      now_r       <= in_now_ms;
      first_due_r <= in_first_due_ms;
      period_r    <= in_period_ms;
      tag_r       <= in_task_tag;
    end
    pend_slot_r  <= pend_slot_nxt;
    pend_tag_r   <= pend_tag_nxt;
    out_idx_r    <= out_idx_nxt;
    out_tag_r    <= out_tag_nxt;
    out_stored_r <= out_stored_nxt;
    out_fired_r  <= out_fired_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Slot memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we_all) begin
      tag_mem[idx_r]    <= tag_r;
      period_mem[idx_r] <= period_r;
    end
    if (mem_we_all || mem_we_due) begin
      due_mem[idx_r] <= mem_wr_due;
    end
    rd_tag_r    <= tag_mem[rd_addr];
    rd_due_r    <= due_mem[rd_addr];
    rd_period_r <= period_mem[rd_addr];
  end

  // Report the slot index modulo 16
  assign out_idx_wide  = {4'b0000, out_idx_r};
  assign out_slot      = out_idx_wide[OUT_SLOT_W-1:0];
  assign out_strobe    = out_strobe_r;
  assign out_fired_tag = out_tag_r;
  assign out_stored    = out_stored_r;
  assign out_fired     = out_fired_r;
  assign out_last      = out_last_r;

  // A result only follows a cycle of work on a transaction
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  // Work only begins on a start
  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // A held tick result never outlives the walk
  a_pend_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (pc_r == PC_TICK_EV || pc_r == PC_TICK_END))
    else $error("held tick result outside a tick walk");

  // A register result is always a lone, final one
  a_stored_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_stored_r) |-> (out_last_r && !out_fired_r))
    else $error("stored result not marked final");

  // Never more reports than the limit
  a_rep_limit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe_r && out_fired_r) |-> (rep_cnt_r <= REP_W'(MAX_REPORTS)))
    else $error("tick report count beyond limit");

endmodule

`default_nettype wire

### tb/periodic_task_table_scheduler_core_tb.sv
// Self-checking testbench for the periodic task table scheduler core.
// Directed table then phased random commands, checked against a local predictor.
// Depends on ptts_pkg and periodic_task_table_scheduler_core.
`timescale 1ns / 100ps

module periodic_task_table_scheduler_core_tb;
  import ptts_pkg::*;

  localparam int unsigned NUM_SLOTS  = 16;
  localparam int unsigned CYC_LIMIT  = 200000;
  localparam int unsigned TAIL_WAIT  = 48;   // ample margin beyond a full tick walk
  localparam int unsigned PHASE_LEN  = 75;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  // One reported slot, as it should appear on the out_ ports
  typedef struct packed {
    logic [OUT_SLOT_W-1:0] slot;
    logic [TAG_W-1:0]      tag;
    logic                  stored;
    logic                  fired;
    logic                  last;
  } report_t;

  // One line of the directed stimulus table
  typedef struct {
    logic [1:0]        cmd;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] first;
    logic [TIME_W-1:0] period;
    logic [TAG_W-1:0]  tag;
    bit                typed;    // expectation written in by hand
    bit                has_rep;  // typed row produces one report
    report_t           rep;
  } cmd_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [1:0]            in_cmd;
  logic [TIME_W-1:0]     in_now_ms;
  logic [TIME_W-1:0]     in_first_due_ms;
  logic [TIME_W-1:0]     in_period_ms;
  logic [TAG_W-1:0]      in_task_tag;
  logic                  out_strobe;
  logic [OUT_SLOT_W-1:0] out_slot;
  logic [TAG_W-1:0]      out_fired_tag;
  logic                  out_stored;
  logic                  out_fired;
  logic                  out_last;

  // Predictor copy of the task table
  logic                  tbl_valid  [NUM_SLOTS];
  logic [TAG_W-1:0]      tbl_tag    [NUM_SLOTS];
  logic [TIME_W-1:0]     tbl_due    [NUM_SLOTS];
  logic [TIME_W-1:0]     tbl_period [NUM_SLOTS];

  report_t  pending_reports[$];
  cmd_row_t script[$];
  int       errors;
  int       cycles;

  periodic_task_table_scheduler_core #(
    .SLOTS(NUM_SLOTS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_now_ms       (in_now_ms),
    .in_first_due_ms (in_first_due_ms),
    .in_period_ms    (in_period_ms),
    .in_task_tag     (in_task_tag),
    .out_strobe      (out_strobe),
    .out_slot        (out_slot),
    .out_fired_tag   (out_fired_tag),
    .out_stored      (out_stored),
    .out_fired       (out_fired),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the table by one command; append the reports it causes when asked to.
  // Ticks use a plain unsigned compare, so due times that wrapped past zero fire at once.
  function automatic void sched_apply(input logic [1:0] cmd, input logic [TIME_W-1:0] now,
                                      input logic [TIME_W-1:0] first,
                                      input logic [TIME_W-1:0] period,
                                      input logic [TAG_W-1:0] tag, input bit keep);
    report_t reps[MAX_REPORTS];
    report_t r;
    int      n;
    bit      done;
    n    = 0;
    done = 1'b0;
    r    = '0;
    case (cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < NUM_SLOTS; i++) tbl_valid[i] = 1'b0;
      end
      CMD_REGISTER: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!done && !tbl_valid[i]) begin
            tbl_valid[i]  = 1'b1;
            tbl_tag[i]    = tag;
            tbl_due[i]    = first;
            tbl_period[i] = period;
            r.slot        = OUT_SLOT_W'(i);
            r.stored      = 1'b1;
            done          = 1'b1;
          end
        end
        // A full table still answers, with stored low and slot zero
        r.last = 1'b1;
        if (keep) pending_reports.push_back(r);
      end
      CMD_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (tbl_valid[i] && tbl_due[i] <= now) begin
            tbl_due[i] = now + tbl_period[i];
            if (n < MAX_REPORTS) begin
              reps[n]       = '0;
              reps[n].slot  = OUT_SLOT_W'(i);
              reps[n].tag   = tbl_tag[i];
              reps[n].fired = 1'b1;
              n++;
            end
          end
        end
        for (int k = 0; k < n; k++) begin
          r      = reps[k];
          r.last = (k == n - 1);
          if (keep) pending_reports.push_back(r);
        end
      end
      default: begin
        // unused code: the block ignores it
      end
    endcase
  endfunction

  function automatic report_t mk_rep(input logic [OUT_SLOT_W-1:0] slot,
                                     input logic [TAG_W-1:0] tag,
                                     input logic stored, input logic fired);
    report_t r;
    r.slot   = slot;
    r.tag    = tag;
    r.stored = stored;
    r.fired  = fired;
    r.last   = 1'b1;
    return r;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic [TIME_W-1:0] now,
                         input logic [TIME_W-1:0] first, input logic [TIME_W-1:0] period,
                         input logic [TAG_W-1:0] tag, input bit typed, input bit has_rep,
                         input report_t rep);
    cmd_row_t row;
    row.cmd     = cmd;
    row.now     = now;
    row.first   = first;
    row.period  = period;
    row.tag     = tag;
    row.typed   = typed;
    row.has_rep = has_rep;
    row.rep     = rep;
    script.push_back(row);
  endtask

  // Present one command transaction from a falling edge and hold it until taken.
  // Start stays high on return, so a following command goes out back to back.
  task automatic send_cmd(input cmd_row_t row);
    start           = 1'b1;
    in_cmd          = row.cmd;
    in_now_ms       = row.now;
    in_first_due_ms = row.first;
    in_period_ms    = row.period;
    in_task_tag     = row.tag;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Taken at this edge: update the table copy, keep hand-written expectations
    if (row.typed) begin
      sched_apply(row.cmd, row.now, row.first, row.period, row.tag, 1'b0);
      if (row.has_rep) pending_reports.push_back(row.rep);
    end else begin
      sched_apply(row.cmd, row.now, row.first, row.period, row.tag, 1'b1);
    end
    @(negedge clk);
  endtask

  // Drop start for a while, from a falling edge
  task automatic hold_off(input int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_reports();
    start = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  // Result monitor: every strobe must match the oldest waiting report
  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: slot %0d tag 0x%0h stored %0b fired %0b last %0b",
               out_slot, out_fired_tag, out_stored, out_fired, out_last);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (out_slot !== want.slot) begin
          $error("out_slot: expected %0d, got %0d", want.slot, out_slot);
          errors++;
        end
        if (out_fired_tag !== want.tag) begin
          $error("out_fired_tag: expected 0x%0h, got 0x%0h", want.tag, out_fired_tag);
          errors++;
        end
        if (out_stored !== want.stored) begin
          $error("out_stored: expected %0b, got %0b", want.stored, out_stored);
          errors++;
        end
        if (out_fired !== want.fired) begin
          $error("out_fired: expected %0b, got %0b", want.fired, out_fired);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0b, got %0b", want.last, out_last);
          errors++;
        end
      end
    end
  end

  // Watchdog: give up well beyond the slowest legal run
  initial begin
    cycles = 0;
    while (cycles < CYC_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    cmd_row_t   row;
    int         idle_pct;
    int         pick;
    logic [TIME_W-1:0] now_base;

    errors          = 0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_cmd          = CMD_CLEAR;
    in_now_ms       = '0;
    in_first_due_ms = '0;
    in_period_ms    = '0;
    in_task_tag     = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_valid[i]  = 1'b0;
      tbl_tag[i]    = '0;
      tbl_due[i]    = '0;
      tbl_period[i] = '0;
    end

    // Directed table. Typed rows carry their expectation; the rest go to the predictor.
    // A tick straight after reset finds an empty table and says nothing
    add_row(CMD_TICK, 32'hFFFF_FFFF, '0, '0, '0, 1'b1, 1'b0, '0);
    // Zero tag, due and period still make a valid slot
    add_row(CMD_REGISTER, '0, 32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b1, 1'b1,
            mk_rep(4'd0, 16'h0000, 1'b1, 1'b0));
    add_row(CMD_REGISTER, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1,
            mk_rep(4'd1, 16'h0000, 1'b1, 1'b0));
    add_row(CMD_TICK, 32'h0000_0000, '0, '0, '0, 1'b1, 1'b1,
            mk_rep(4'd0, 16'h0000, 1'b0, 1'b1));
    // Both due at the top of the range; slot 1's next due time wraps
    add_row(CMD_TICK, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, 1'b0, '0);
    add_row(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0,
            '0);
    // Fill the remaining slots with walking bit patterns
    for (int i = 2; i < NUM_SLOTS; i++)
      add_row(CMD_REGISTER, '0, 32'h1 << (2 * i), ~(32'h1 << (2 * i)), 16'h1 << i, 1'b0,
              1'b0, '0);
    // Full table: nothing stored, slot reads zero
    add_row(CMD_REGISTER, '0, 32'h1234_5678, 32'h9ABC_DEF0, 16'h5A5A, 1'b1, 1'b1,
            mk_rep(4'd0, 16'h0000, 1'b0, 1'b0));
    // Every slot due at once: sixteen reports, last on the final one
    add_row(CMD_TICK, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, 1'b0, '0);
    add_row(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0,
            '0);
    add_row(CMD_REGISTER, '0, 32'h8000_0000, 32'h0000_0005, 16'hA5A5, 1'b1, 1'b1,
            mk_rep(4'd0, 16'h0000, 1'b1, 1'b0));
    add_row(CMD_TICK, 32'h8000_0000, '0, '0, '0, 1'b0, 1'b0, '0);

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (script[i]) send_cmd(script[i]);
    drain_reports();
    // Start the random part from an empty table
    row = '{cmd: CMD_CLEAR, now: '0, first: '0, period: '0, tag: '0,
            typed: 1'b0, has_rep: 1'b0, rep: '0};
    send_cmd(row);

    // Random phases: no gaps, heavy gaps, light gaps, then back to back again.
    // Time mostly creeps forward so that registered tasks come due and repeat;
    // the third phase runs across the wrap of the millisecond counter.
    now_base = '0;
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 53 : (phase == 2) ? 22 : 0;
      if (phase == 2) now_base = 32'hFFFF_FE00;
      for (int k = 0; k < PHASE_LEN; k++) begin
        pick       = $urandom_range(99);
        row.typed  = 1'b0;
        row.now    = $urandom;
        row.first  = $urandom;
        row.period = $urandom;
        row.tag    = TAG_W'($urandom);
        if (pick < 4) begin
          row.cmd = CMD_CLEAR;
        end else if (pick < 7) begin
          row.cmd = CMD_UNUSED;
        end else if (pick < 45) begin
          row.cmd = CMD_REGISTER;
          // Mostly near-term tasks with short periods; some anywhere in range
          if ($urandom_range(99) < 80) begin
            row.first  = now_base + $urandom_range(0, 60);
            row.period = $urandom_range(0, 50);
          end
        end else begin
          row.cmd = CMD_TICK;
          if ($urandom_range(99) < 85) begin
            now_base = now_base + $urandom_range(0, 12);
            row.now  = now_base;
          end
        end
        send_cmd(row);
        if ($urandom_range(99) < idle_pct) hold_off($urandom_range(1, 24));
      end
      // Let the block fall quiet once before carrying on
      if (phase == 0) drain_reports();
    end

    // Wait for the last reports, then for a full tick walk on top
    drain_reports();
    repeat (TAIL_WAIT) @(negedge clk);

    if (errors == 0 && pending_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
